FILE: sv/scalar_kalman_smoother_core_assert.svh
// Assertion macros for the scalar Kalman smoother core.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SCALAR_KALMAN_SMOOTHER_CORE_ASSERT_SVH
`define SCALAR_KALMAN_SMOOTHER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/skc_pkg.sv
// Package for the scalar Kalman smoother core: widths, reset values,
// register indexes, controller states and the controller command bundle.
// Used by skc_ctrl, skc_dp and scalar_kalman_smoother_core.
package skc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int EST_W     = 32;
    localparam int COV_W     = 32;
    localparam int CFG_W     = 32;
    localparam int GAIN_BITS = 16;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

    // One quotient bit per divider step, from the 1.0 bit down.
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CFG_W-1:0] PROCESS_NOISE_RST = 32'd655;
    localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = 32'd65536;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_NOISE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEASURE_NOISE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_GAIN,
        ST_MUL_EST,
        ST_MUL_COV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;      // capture the sample and the predicted covariance
        logic prep;      // form the denominator and innovation, seed the divider
        logic div_step;  // one restoring division step
        logic gain_set;  // fix the gain, covering the zero denominator
        logic mul_est;   // innovation times gain
        logic mul_cov;   // covariance times one minus gain, round the correction
        logic write;     // update state and present the result
    } cmd_t;

endpackage

FILE: sv/scalar_kalman_smoother_core.sv
// Scalar Kalman smoother core: a one-dimensional Kalman filter with a
// constant-state model in Q16.16 fixed point. Each sample request yields one
// result request carrying the new estimate and the Q1.16 gain that was used.
// The time per sample is set by the restoring divider that forms the gain,
// one quotient bit per cycle, plus prediction, the two products on the
// shared multiplier and the state update. The block works on one sample at
// a time but takes the next sample while the previous result still waits in
// its output register; it stalls only if that result is still unread when
// the next one is finished. The noise registers may be written at any time
// but should only change while the block is idle. Depends on skc_pkg,
// skc_ctrl, skc_dp and the assertion header.
module scalar_kalman_smoother_core #(
    parameter int SAMPLE_WIDTH = skc_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = skc_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [skc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [skc_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]   sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic signed [skc_pkg::EST_W-1:0] estimate,
    output logic [skc_pkg::GAIN_W-1:0]       gain
);
    import skc_pkg::*;

`include "scalar_kalman_smoother_core_assert.svh"

    logic [CFG_W-1:0] process_noise_reg, process_noise_next;
    logic [CFG_W-1:0] measure_noise_reg, measure_noise_next;
    cmd_t             cmd;

    // Noise registers. Both indexes are decoded, so every write lands.
    always_comb
    begin
        process_noise_next = process_noise_reg;
        measure_noise_next = measure_noise_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROCESS_NOISE: process_noise_next = cfg_data;
                CFG_MEASURE_NOISE: measure_noise_next = cfg_data;
                default:           process_noise_next = process_noise_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_noise_reg <= PROCESS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
        end
        else
        begin
            process_noise_reg <= process_noise_next;
            measure_noise_reg <= measure_noise_next;
        end
    end

    // The controller sequences each sample; the datapath holds the filter
    // state and does the arithmetic under its commands.
    skc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    skc_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sample        (sample),
        .process_noise (process_noise_reg),
        .measure_noise (measure_noise_reg),
        .estimate      (estimate),
        .gain          (gain)
    );

    // A presented gain never exceeds one.
    `SKC_ASSERT_SAME(a_gain_range, result_valid, gain <= GAIN_ONE, "gain above one")
    // Only one sample is in work at a time.
    `SKC_ASSERT_NEXT(a_one_in_flight, sample_valid && sample_ready, !sample_ready, "second sample taken")
    // A new result never overwrites one that has not been taken.
    `SKC_ASSERT_SAME(a_no_overwrite, cmd.write, !result_valid || result_ready, "result overwritten")
    // A finished update is always presented in the next cycle.
    `SKC_ASSERT_NEXT(a_write_shown, cmd.write, result_valid, "result not presented")

endmodule

FILE: sv/skc_ctrl.sv
// Controller of the scalar Kalman smoother: sequences one request through
// the datapath and owns both handshakes. Depends on skc_pkg.
module skc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    output logic          sample_ready,
    output logic          result_valid,
    input  logic          result_ready,
    output skc_pkg::cmd_t cmd
);
    import skc_pkg::*;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 result_valid_reg, result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            div_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            div_cnt_reg      <= div_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep     = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                cmd.gain_set = 1'b1;
                state_next   = ST_MUL_EST;
            end
            ST_MUL_EST:
            begin
                cmd.mul_est = 1'b1;
                state_next  = ST_MUL_COV;
            end
            ST_MUL_COV:
            begin
                cmd.mul_cov = 1'b1;
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                // The result register must be free before it is overwritten.
                if (!result_valid_reg || result_ready)
                begin
                    cmd.write  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.write)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

FILE: sv/skc_dp.sv
// Datapath of the scalar Kalman smoother: filter state, restoring divider
// for the gain, one shared multiplier and the saturating updates.
// Depends on skc_pkg; driven by the command bundle from skc_ctrl.
module skc_dp #(
    parameter int SAMPLE_WIDTH = skc_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRAC_BITS    = skc_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  skc_pkg::cmd_t                  cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic [skc_pkg::CFG_W-1:0]      process_noise,
    input  logic [skc_pkg::CFG_W-1:0]      measure_noise,
    output logic signed [skc_pkg::EST_W-1:0] estimate,
    output logic [skc_pkg::GAIN_W-1:0]     gain
);
    import skc_pkg::*;

    localparam int INNOV_W = EST_W + 1;
    localparam int MEAS_W  = (SAMPLE_WIDTH + FRAC_BITS > INNOV_W) ?
                             SAMPLE_WIDTH + FRAC_BITS : INNOV_W;
    localparam int DEN_W   = COV_W + 1;
    localparam int REM_W   = DEN_W + 2;
    localparam int MUL_A_W = INNOV_W + 1;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DELTA_W = PROD_W - GAIN_BITS;
    localparam int SUM_W   = DELTA_W + 1;

    localparam logic [COV_W-1:0] COV_RST = COV_W'(1) << FRAC_BITS;
    localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
    localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (GAIN_BITS - 1);

    logic signed [EST_W-1:0]        estimate_reg;
    logic [COV_W-1:0]               covariance_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [COV_W-1:0]               pnow_reg;
    logic [DEN_W-1:0]               denom_reg;
    logic [REM_W-1:0]               rem_reg;
    logic [GAIN_W-1:0]              quot_reg;
    logic [GAIN_W-1:0]              gain_reg;
    logic [GAIN_W-1:0]              gain_out_reg;
    logic signed [INNOV_W-1:0]      innov_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [DELTA_W-1:0]      delta_reg;

    logic [COV_W:0]                 psum;
    logic [COV_W-1:0]               pnow_next;
    logic signed [MEAS_W-1:0]       meas_wide;
    logic [MEAS_W-EST_W:0]          meas_hi;
    logic signed [EST_W-1:0]        meas_sat;
    logic signed [INNOV_W-1:0]      innov_next;
    logic [REM_W-1:0]               denom_ext;
    logic [REM_W-1:0]               rem_diff;
    logic [REM_W-1:0]               rem_keep;
    logic                           rem_ge;
    logic signed [MUL_A_W-1:0]      mul_a;
    logic signed [MUL_B_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]       prod_rnd;
    logic signed [SUM_W-1:0]        est_sum;
    logic [SUM_W-EST_W:0]           sum_hi;
    logic signed [EST_W-1:0]        est_sat;

    // Predicted covariance, saturating at all ones.
    assign psum      = {1'b0, covariance_reg} + {1'b0, process_noise};
    assign pnow_next = psum[COV_W] ? '1 : psum[COV_W-1:0];

    // Scaled measurement, clamped to the signed estimate range.
    assign meas_wide = MEAS_W'(sample_reg) <<< FRAC_BITS;
    assign meas_hi   = meas_wide[MEAS_W-1:EST_W-1];
    assign meas_sat  = ((&meas_hi) || !(|meas_hi)) ? meas_wide[EST_W-1:0] :
                       (meas_wide[MEAS_W-1] ? EST_MIN : EST_MAX);
    assign innov_next = {meas_sat[EST_W-1], meas_sat} - {estimate_reg[EST_W-1], estimate_reg};

    // Restoring divider, one quotient bit per step.
    assign denom_ext = REM_W'(denom_reg);
    assign rem_ge    = rem_reg >= denom_ext;
    assign rem_diff  = rem_reg - denom_ext;
    assign rem_keep  = rem_ge ? rem_diff : rem_reg;

    // Shared multiplier operands.
    assign mul_a = cmd.mul_cov ? MUL_A_W'(pnow_reg) : MUL_A_W'(innov_reg);
    assign mul_b = cmd.mul_cov ? MUL_B_W'(GAIN_ONE - gain_reg) : MUL_B_W'(gain_reg);

    assign prod_rnd = prod_reg + ROUND_HALF;

    // Estimate update, clamped to the signed estimate range.
    assign est_sum = SUM_W'(estimate_reg) + SUM_W'(delta_reg);
    assign sum_hi  = est_sum[SUM_W-1:EST_W-1];
    assign est_sat = ((&sum_hi) || !(|sum_hi)) ? est_sum[EST_W-1:0] :
                     (est_sum[SUM_W-1] ? EST_MIN : EST_MAX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estimate_reg   <= '0;
            covariance_reg <= COV_RST;
        end
        else if (cmd.write)
        begin
            estimate_reg   <= est_sat;
            covariance_reg <= prod_reg[GAIN_BITS +: COV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            pnow_reg   <= pnow_next;
        end
        if (cmd.prep)
        begin
            denom_reg <= {1'b0, pnow_reg} + {1'b0, measure_noise};
            rem_reg   <= REM_W'(pnow_reg);
            innov_reg <= innov_next;
        end
        if (cmd.div_step)
        begin
            rem_reg  <= {rem_keep[REM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[GAIN_W-2:0], rem_ge};
        end
        if (cmd.gain_set)
        begin
            gain_reg <= (denom_reg == '0) ? GAIN_ONE : quot_reg;
        end
        if (cmd.mul_est || cmd.mul_cov)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.mul_cov)
        begin
            delta_reg <= prod_rnd[PROD_W-1:GAIN_BITS];
        end
        if (cmd.write)
        begin
            gain_out_reg <= gain_reg;
        end
    end

    assign estimate = estimate_reg;
    assign gain     = gain_out_reg;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for scalar_kalman_smoother_core. It mirrors the filter and compares
// every estimate and gain. Directed and random samples are driven under random idling.
// Depends on skc_pkg and the RTL of the core only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skc_pkg::*;

    localparam int SW            = SAMPLE_WIDTH_DEF;
    localparam int FB            = FRAC_BITS_DEF;
    localparam int IDLE_PCT      = 35;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_SAMPLES = 166;
    localparam int DRAIN_CYCLES  = 25;

    typedef struct packed {
        logic signed [EST_W-1:0] est;
        logic [GAIN_W-1:0]       gain;
    } filt_out_t;

    // Mirror of the filter: its own noise settings, estimate and covariance, and the
    // outputs still owed by the core, oldest first.
    class kalman_mirror;
        logic [CFG_W-1:0]        q_noise;
        logic [CFG_W-1:0]        r_noise;
        logic signed [EST_W-1:0] est_q;
        logic [COV_W-1:0]        cov_q;
        filt_out_t               due_outputs[$];
        int unsigned             errors;
        int unsigned             outputs_seen;

        function new();
            q_noise      = PROCESS_NOISE_RST;
            r_noise      = MEASURE_NOISE_RST;
            est_q        = '0;
            cov_q        = COV_W'(1) << FB;
            errors       = 0;
            outputs_seen = 0;
        endfunction

        function longint clamp_s32(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< 31) - 1;
            lo = -(longint'(1) <<< 31);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        task log_mismatch(string msg);
            $display("[%0t] output %0d: %s", $realtime, outputs_seen, msg);
            errors++;
        endtask

        // Predict, gain, correct and shrink the covariance for one accepted sample.
        function void note_sample(logic signed [SW-1:0] s);
            longint    p_pred;
            longint    denom;
            longint    g;
            longint    meas;
            longint    innov;
            longint    delta;
            filt_out_t o;
            p_pred = longint'(cov_q) + longint'(q_noise);
            if (p_pred > longint'(32'hFFFF_FFFF))
                p_pred = longint'(32'hFFFF_FFFF);
            denom = p_pred + longint'(r_noise);
            if (denom == 0)
                g = longint'(GAIN_ONE);
            else
                g = (p_pred << GAIN_BITS) / denom;
            meas  = clamp_s32(longint'(s) * (longint'(1) <<< FB));
            innov = meas - longint'(est_q);
            // Round half up, then floor: an arithmetic shift floors negative values.
            delta = (innov * g + (longint'(1) <<< (GAIN_BITS - 1))) >>> GAIN_BITS;
            est_q = EST_W'(clamp_s32(longint'(est_q) + delta));
            cov_q = COV_W'(((longint'(GAIN_ONE) - g) * p_pred) >> GAIN_BITS);
            o.est  = est_q;
            o.gain = GAIN_W'(g);
            due_outputs.push_back(o);
        endfunction

        task check_output(logic signed [EST_W-1:0] e, logic [GAIN_W-1:0] g);
            filt_out_t want;
            outputs_seen++;
            if (due_outputs.size() == 0)
            begin
                log_mismatch("result request with no sample outstanding");
                return;
            end
            want = due_outputs.pop_front();
            if (e !== want.est)
                log_mismatch($sformatf("estimate %h, expected %h", e, want.est));
            if (g !== want.gain)
                log_mismatch($sformatf("gain %h, expected %h", g, want.gain));
        endtask
    endclass

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index    = CFG_PROCESS_NOISE;
    logic [CFG_W-1:0]        cfg_data     = '0;
    logic                    sample_valid = 1'b0;
    logic                    sample_ready;
    logic signed [SW-1:0]    sample       = '0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    logic signed [EST_W-1:0] estimate;
    logic [GAIN_W-1:0]       gain;

    // When set, neither side idles: the long stretch at full rate.
    logic                    steady       = 1'b0;
    int unsigned             quiet_cycles = 0;

    kalman_mirror mirror = new();

    scalar_kalman_smoother_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .estimate     (estimate),
        .gain         (gain)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side. Outputs are read at the clock edge, so the values seen are those from
    // before the edge; the ready for the next cycle is drawn at random here as well.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            mirror.check_output(estimate, gain);
        result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: any cycle with an accepted request on either side clears the count.
    always @(posedge clk)
    begin
        if ((sample_valid && sample_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("scalar_kalman_smoother_core: mismatch");
            $finish;
        end
    end

    // Offer one sample request and hold it until it is accepted. After acceptance the valid
    // is left high: the next call either lowers it for an idle gap or simply changes the
    // payload, so valid never gets two assignments in one step.
    task send_sample(logic signed [SW-1:0] v);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= v;
        do
            @(posedge clk);
        while (!sample_ready);
        mirror.note_sample(v);
    endtask

    // Stop offering samples and wait until every owed result has been taken, then let a
    // few more cycles pass. This is also the point where the noise registers may change.
    task drain(int extra);
        sample_valid <= 1'b0;
        while (mirror.due_outputs.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Both registers are written back to back; write enable drops after the second.
    task set_noise(logic [CFG_W-1:0] q, logic [CFG_W-1:0] r);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PROCESS_NOISE;
        cfg_data  <= q;
        @(posedge clk);
        cfg_index <= CFG_MEASURE_NOISE;
        cfg_data  <= r;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mirror.q_noise = q;
        mirror.r_noise = r;
    endtask

    // Noise settings: mostly between zero and 16.0, with zero, all ones and fully
    // random values mixed in.
    function automatic logic [CFG_W-1:0] pick_noise();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        if (roll <= 3)
            return CFG_W'($urandom);
        return CFG_W'($urandom_range(1 << 20));
    endfunction

    // Mostly a noisy reading of a fixed level, which is what the filter is built for, with
    // some wild readings and range extremes thrown in.
    function automatic logic signed [SW-1:0] pick_sample(int level, int spread);
        int roll;
        int v;
        roll = $urandom_range(99);
        if (roll < 12)
            return SW'($urandom);
        if (roll < 16)
            return (roll < 14) ? {1'b0, {(SW-1){1'b1}}} : {1'b1, {(SW-1){1'b0}}};
        v = level + int'($urandom_range(2 * spread)) - spread;
        if (v > (1 << (SW - 1)) - 1)
            v = (1 << (SW - 1)) - 1;
        if (v < -(1 << (SW - 1)))
            v = -(1 << (SW - 1));
        return SW'(v);
    endfunction

    initial
    begin
        int level;
        int spread;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero, both range extremes back to back, unit steps and
        // alternating bit patterns.
        send_sample(16'sd0);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        drain(4);

        // Largest process noise: the predicted covariance saturates. With no measurement
        // noise the gain is exactly one, which also leaves the covariance at zero.
        set_noise('1, '0);
        send_sample(16'sd100);
        send_sample(-16'sd100);
        send_sample(16'sh7FFF);
        drain(4);

        // No noise at all and a covariance of zero: the denominator is zero, gain is one.
        set_noise('0, '0);
        send_sample(-16'sh8000);
        send_sample(16'sd0);
        send_sample(16'sd12345);
        drain(4);

        // Largest measurement noise: the gain collapses towards zero.
        set_noise('0, '1);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sd7);
        drain(4);

        // Random phases, each with its own noise settings and signal level. The third one
        // runs with no idling on either side.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            set_noise(pick_noise(), pick_noise());
            steady <= (ph == 2);
            level  = int'(SW'($urandom)) - (1 << (SW - 1));
            case ($urandom_range(3))
                0: spread = 0;
                1: spread = 4;
                2: spread = 200;
                default: spread = 1 << (SW - 1);
            endcase
            for (int n = 0; n < PHASE_SAMPLES; n++)
                send_sample(pick_sample(level, spread));
            drain(4);
        end

        steady <= 1'b0;
        drain(DRAIN_CYCLES);
        if (mirror.errors == 0)
            $display("scalar_kalman_smoother_core: match");
        else
            $display("scalar_kalman_smoother_core: mismatch");
        $finish;
    end

endmodule
